// ===== design/owm_pkg.sv =====
`timescale 1ns / 1ps

package owm_pkg;

	// command codes carried by op
	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_RESET = 2'd1;
	localparam logic [1:0] OP_WRITE = 2'd2;
	localparam logic [1:0] OP_READ  = 2'd3;

	// timing register bank
	localparam int NUM_REGS  = 8;
	localparam int REG_W     = 10;
	localparam int REG_IDX_W = 4;
	localparam int REG_SEL_W = 3;

	localparam logic [REG_SEL_W-1:0] REG_RESET_LOW     = 3'd0;
	localparam logic [REG_SEL_W-1:0] REG_PRESENCE_WAIT = 3'd1;
	localparam logic [REG_SEL_W-1:0] REG_RESET_TAIL    = 3'd2;
	localparam logic [REG_SEL_W-1:0] REG_SHORT_LOW     = 3'd3;
	localparam logic [REG_SEL_W-1:0] REG_LONG_PHASE    = 3'd4;
	localparam logic [REG_SEL_W-1:0] REG_SHORT_RECOV   = 3'd5;
	localparam logic [REG_SEL_W-1:0] REG_READ_SAMPLE   = 3'd6;
	localparam logic [REG_SEL_W-1:0] REG_READ_TAIL     = 3'd7;

	typedef logic [REG_W-1:0] reg_val_t;
	typedef reg_val_t [NUM_REGS-1:0] reg_bank_t;

	// values after reset
	localparam reg_bank_t REG_INIT = '{
		7: 10'd50,
		6: 10'd10,
		5: 10'd2,
		4: 10'd60,
		3: 10'd2,
		2: 10'd400,
		1: 10'd80,
		0: 10'd480
	};

endpackage

// ===== design/onewire_bus_master.sv =====
`timescale 1ns / 1ps
// each input transfer's result is captured in the output register on the clock edge that takes the transfer
// throughput: one item per cycle while the result side takes every transfer
// the whole step is one pass of next-state logic ahead of the state and result registers
// reset: arst_n clears the sequencer to idle, timing registers to their defaults,
// presence and read byte to zero, and empties the result register

module onewire_bus_master
	import owm_pkg::*;
#(
	parameter int TIMER_WIDTH = 10
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [REG_W-1:0]     cfg_wdata,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           op,
	input  logic [7:0]           data_byte,
	input  logic                 bus_sample,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 drive_low,
	output logic                 busy_res,
	output logic                 done_res,
	output logic                 presence,
	output logic [7:0]           read_value,
	output logic                 rejected
);

	localparam int CMP_W = (TIMER_WIDTH > REG_W) ? TIMER_WIDTH : REG_W;
	localparam logic [TIMER_WIDTH-1:0] TMAX = {TIMER_WIDTH{1'b1}};

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_RST_LOW,
		PH_RST_WAIT,
		PH_RST_TAIL,
		PH_SLOT_LOW,
		PH_SLOT_MID,
		PH_SLOT_TAIL
	} phase_t;

	typedef logic [TIMER_WIDTH-1:0] tmr_t;

	reg_bank_t regs;
	tmr_t      len [NUM_REGS];

	phase_t     phase_q, phase_n;
	tmr_t       timer_q, timer_n, timer_dec;
	logic [2:0] bit_q, bit_n;
	logic [7:0] shift_q, shift_n;
	logic       pres_q, pres_n;
	logic       is_read_q, is_read_n;
	logic [7:0] last_read_q, last_read_n;
	logic       done_n, rej_n;
	logic       in_xfer;
	logic       out_valid_q;

	owm_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.regs      (regs)
	);

	// phase lengths: zero counts as one tick, large values saturate to the timer range
	always_comb begin
		for (int i = 0; i < NUM_REGS; i++) begin
			if (regs[i] == '0) begin
				len[i] = tmr_t'(1);
			end else if (CMP_W'(regs[i]) > CMP_W'(TMAX)) begin
				len[i] = TMAX;
			end else begin
				len[i] = tmr_t'(CMP_W'(regs[i]));
			end
		end
	end

	assign timer_dec = timer_q - tmr_t'(1);

	// next state and result for the item on the input
	always_comb begin
		phase_n     = phase_q;
		timer_n     = timer_q;
		bit_n       = bit_q;
		shift_n     = shift_q;
		pres_n      = pres_q;
		is_read_n   = is_read_q;
		last_read_n = last_read_q;
		done_n      = 1'b0;
		rej_n       = 1'b0;

		if (op != OP_TICK) begin
			if (phase_q != PH_IDLE) begin
				rej_n = 1'b1;
			end else if (op == OP_RESET) begin
				is_read_n = 1'b0;
				phase_n   = PH_RST_LOW;
				timer_n   = len[REG_RESET_LOW];
			end else begin
				is_read_n = (op == OP_READ);
				shift_n   = (op == OP_READ) ? 8'd0 : data_byte;
				bit_n     = 3'd0;
				phase_n   = PH_SLOT_LOW;
				timer_n   = ((op == OP_READ) || data_byte[0]) ?
				            len[REG_SHORT_LOW] : len[REG_LONG_PHASE];
			end
		end else if (phase_q != PH_IDLE) begin
			timer_n = timer_dec;
			if (timer_dec == '0) begin
				case (phase_q)
					PH_RST_LOW: begin
						phase_n = PH_RST_WAIT;
						timer_n = len[REG_PRESENCE_WAIT];
					end
					PH_RST_WAIT: begin
						pres_n  = ~bus_sample;
						phase_n = PH_RST_TAIL;
						timer_n = len[REG_RESET_TAIL];
					end
					PH_RST_TAIL: begin
						phase_n = PH_IDLE;
						timer_n = '0;
						done_n  = 1'b1;
					end
					PH_SLOT_LOW: begin
						phase_n = PH_SLOT_MID;
						if (is_read_q) begin
							timer_n = len[REG_READ_SAMPLE];
						end else if (shift_q[0]) begin
							timer_n = len[REG_LONG_PHASE];
						end else begin
							timer_n = len[REG_SHORT_RECOV];
						end
					end
					PH_SLOT_MID, PH_SLOT_TAIL: begin
						if (is_read_q && (phase_q == PH_SLOT_MID)) begin
							// read sample point
							shift_n = {bus_sample, shift_q[7:1]};
							phase_n = PH_SLOT_TAIL;
							timer_n = len[REG_READ_TAIL];
						end else begin
							// end of bit slot
							shift_n = is_read_q ? shift_q : {1'b0, shift_q[7:1]};
							bit_n   = bit_q + 3'd1;
							if (bit_q == 3'd7) begin
								phase_n = PH_IDLE;
								timer_n = '0;
								done_n  = 1'b1;
								if (is_read_q) begin
									last_read_n = shift_q;
								end
							end else begin
								phase_n = PH_SLOT_LOW;
								timer_n = (is_read_q || shift_n[0]) ?
								          len[REG_SHORT_LOW] : len[REG_LONG_PHASE];
							end
						end
					end
					default: begin
						phase_n = PH_IDLE;
						timer_n = '0;
					end
				endcase
			end
		end
	end

	// result register frees itself when the result side takes its transfer
	assign in_ready = !out_valid_q || out_ready;
	assign in_xfer  = in_valid && in_ready;

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			timer_q     <= '0;
			bit_q       <= 3'd0;
			shift_q     <= 8'd0;
			pres_q      <= 1'b0;
			is_read_q   <= 1'b0;
			last_read_q <= 8'd0;
		end else if (in_xfer) begin
			phase_q     <= phase_n;
			timer_q     <= timer_n;
			bit_q       <= bit_n;
			shift_q     <= shift_n;
			pres_q      <= pres_n;
			is_read_q   <= is_read_n;
			last_read_q <= last_read_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_xfer) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			drive_low  <= (phase_n == PH_RST_LOW) || (phase_n == PH_SLOT_LOW);
			busy_res   <= (phase_n != PH_IDLE);
			done_res   <= done_n;
			presence   <= pres_n;
			read_value <= last_read_n;
			rejected   <= rej_n;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== design/owm_regs.sv =====
`timescale 1ns / 1ps

module owm_regs
	import owm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [REG_W-1:0]     cfg_wdata,
	output reg_bank_t            regs
);

	reg_bank_t regs_q;

	// timing registers, writes beyond the bank are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= REG_INIT;
		end else if (cfg_we && (cfg_index < REG_IDX_W'(NUM_REGS))) begin
			regs_q[cfg_index[$clog2(NUM_REGS)-1:0]] <= cfg_wdata;
		end
	end

	assign regs = regs_q;

endmodule
